// ----- rtl/s5c_pkg.sv -----
// Shared types, protocol constants and request byte generation for the SOCKS5 client.
package s5c_pkg;

    // Protocol bytes
    localparam logic [7:0] SOCKS_VER     = 8'h05;
    localparam logic [7:0] NUM_METHODS   = 8'h01;
    localparam logic [7:0] METHOD_NONE   = 8'h00;
    localparam logic [7:0] METHOD_REJECT = 8'hFF;
    localparam logic [7:0] CMD_CONNECT   = 8'h01;
    localparam logic [7:0] RSV_BYTE      = 8'h00;
    localparam logic [7:0] REP_SUCCESS   = 8'h00;
    localparam logic [7:0] REP_CODE_MIN  = 8'h01;
    localparam logic [7:0] REP_CODE_MAX  = 8'h08;
    localparam logic [7:0] ATYP_V4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_V6       = 8'h04;

    // Input commands and result kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RX    = 1'b1;
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Outcome status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_VER    = 4'd1;
    localparam logic [3:0] ST_AUTH_REQ   = 4'd2;
    localparam logic [3:0] ST_BAD_METHOD = 4'd3;
    localparam logic [3:0] ST_REPLY_BASE = 4'd3;
    localparam logic [3:0] ST_UNKNOWN    = 4'd12;
    localparam logic [3:0] ST_RSV_NZ     = 4'd13;
    localparam logic [3:0] ST_DOMAIN     = 4'd14;
    localparam logic [3:0] ST_BAD_ATYP   = 4'd15;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IS_V6 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HI    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PORT  = 2'd3;

    // Byte positions in messages
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] POS_VER      = 5'd0;
    localparam logic [IDX_W-1:0] POS_REP      = 5'd1;
    localparam logic [IDX_W-1:0] POS_RSV      = 5'd2;
    localparam logic [IDX_W-1:0] POS_ATYP     = 5'd3;
    localparam logic [IDX_W-1:0] POS_V4_END   = 5'd8;
    localparam logic [IDX_W-1:0] POS_V6_HI_END = 5'd12;
    localparam logic [IDX_W-1:0] POS_V6_END   = 5'd20;
    localparam logic [IDX_W-1:0] POS_V6_LO_LAST = 5'd19;
    localparam logic [IDX_W-1:0] POS_V6_HI_LAST = 5'd11;
    localparam logic [IDX_W-1:0] POS_V4_LAST  = 5'd7;
    localparam logic [IDX_W-1:0] LAST_HELLO   = 5'd2;
    localparam logic [IDX_W-1:0] LAST_V4      = 5'd9;
    localparam logic [IDX_W-1:0] LAST_V6      = 5'd21;
    localparam logic [IDX_W-1:0] IDX_ONE      = 5'd1;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_METHOD = 4'b0010,
        PH_REPLY  = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_HELLO   = 2'd1,
        ACT_CONNECT = 2'd2,
        ACT_REPORT  = 2'd3
    } t_act;

    typedef enum logic {
        MSG_HELLO   = 1'b0,
        MSG_CONNECT = 1'b1
    } t_msg;

    // What the parser asks the emitter to do for one input item
    typedef struct packed {
        t_act        act;
        logic [3:0]  status;
        logic        bound_v6;
        logic [63:0] bound_hi;
        logic [63:0] bound_lo;
        logic [15:0] bound_port;
    } t_action;

    // Byte at position idx of the method request or the connect request
    function automatic logic [7:0] msg_byte(t_msg msg, logic [IDX_W-1:0] idx, logic v6,
                                            logic [63:0] hi, logic [63:0] lo,
                                            logic [15:0] port);
        logic [7:0]       b;
        logic [IDX_W-1:0] k;
        b = 8'h00;
        k = '0;
        if (msg == MSG_HELLO) begin
            case (idx)
                POS_VER: b = SOCKS_VER;
                POS_REP: b = NUM_METHODS;
                POS_RSV: b = METHOD_NONE;
                default: b = 8'h00;
            endcase
        end else if (idx <= POS_ATYP) begin
            case (idx)
                POS_VER:  b = SOCKS_VER;
                POS_REP:  b = CMD_CONNECT;
                POS_RSV:  b = RSV_BYTE;
                POS_ATYP: b = v6 ? ATYP_V6 : ATYP_V4;
                default:  b = 8'h00;
            endcase
        end else if (v6) begin
            if (idx < POS_V6_HI_END) begin
                k = POS_V6_HI_LAST - idx;
                b = hi[{k[2:0], 3'b000} +: 8];
            end else if (idx < POS_V6_END) begin
                k = POS_V6_LO_LAST - idx;
                b = lo[{k[2:0], 3'b000} +: 8];
            end else if (idx == POS_V6_END) begin
                b = port[15:8];
            end else begin
                b = port[7:0];
            end
        end else begin
            if (idx < POS_V4_END) begin
                k = POS_V4_LAST - idx;
                b = lo[{k[2:0], 3'b000} +: 8];
            end else if (idx == POS_V4_END) begin
                b = port[15:8];
            end else begin
                b = port[7:0];
            end
        end
        return b;
    endfunction

    // Position of the final byte of a request message
    function automatic logic [IDX_W-1:0] msg_last_idx(t_msg msg, logic v6);
        logic [IDX_W-1:0] l;
        if (msg == MSG_HELLO) begin
            l = LAST_HELLO;
        end else begin
            l = v6 ? LAST_V6 : LAST_V4;
        end
        return l;
    endfunction

endpackage

// ----- rtl/s5c_parser.sv -----
// Reply parser: checks server bytes, tracks handshake phase, collects the bound endpoint.
module s5c_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_command,
    input  logic [7:0]           i_rx_byte,
    output s5c_pkg::t_action     o_action
);

    s5c_pkg::t_phase               r_phase, n_phase;
    logic [s5c_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                          r_vbad, n_vbad;
    logic                          r_v6, n_v6;
    logic [63:0]                   r_hacc, n_hacc;
    logic [63:0]                   r_lacc, n_lacc;
    logic [15:0]                   r_pacc, n_pacc;
    s5c_pkg::t_action              w_act;
    logic [s5c_pkg::IDX_W-1:0]     w_addr_end;
    logic [s5c_pkg::IDX_W-1:0]     w_idx_inc;

    assign w_addr_end = r_v6 ? s5c_pkg::POS_V6_END : s5c_pkg::POS_V4_END;
    assign w_idx_inc  = r_idx + s5c_pkg::IDX_ONE;

    // Decide the action and the next parser state for the presented item
    always_comb begin
        w_act            = '0;
        w_act.act        = s5c_pkg::ACT_NONE;
        w_act.status     = s5c_pkg::ST_OK;
        n_phase          = r_phase;
        n_idx            = r_idx;
        n_vbad           = r_vbad;
        n_v6             = r_v6;
        n_hacc           = r_hacc;
        n_lacc           = r_lacc;
        n_pacc           = r_pacc;
        if (i_command == s5c_pkg::CMD_START) begin
            if (r_phase == s5c_pkg::PH_IDLE) begin
                w_act.act = s5c_pkg::ACT_HELLO;
                n_phase   = s5c_pkg::PH_METHOD;
                n_idx     = '0;
                n_vbad    = 1'b0;
            end
        end else begin
            case (r_phase)
                s5c_pkg::PH_METHOD: begin
                    if (r_idx == s5c_pkg::POS_VER) begin
                        n_vbad = (i_rx_byte != s5c_pkg::SOCKS_VER);
                        n_idx  = s5c_pkg::IDX_ONE;
                    end else begin
                        w_act.act = s5c_pkg::ACT_REPORT;
                        n_phase   = s5c_pkg::PH_DONE;
                        if (r_vbad) begin
                            w_act.status = s5c_pkg::ST_BAD_VER;
                        end else if (i_rx_byte == s5c_pkg::METHOD_REJECT) begin
                            w_act.status = s5c_pkg::ST_AUTH_REQ;
                        end else if (i_rx_byte != s5c_pkg::METHOD_NONE) begin
                            w_act.status = s5c_pkg::ST_BAD_METHOD;
                        end else begin
                            // good method reply: send the connect request
                            w_act.act = s5c_pkg::ACT_CONNECT;
                            n_phase   = s5c_pkg::PH_REPLY;
                            n_idx     = '0;
                            n_vbad    = 1'b0;
                        end
                    end
                end
                s5c_pkg::PH_REPLY: begin
                    n_idx = w_idx_inc;
                    if (r_idx == s5c_pkg::POS_VER) begin
                        n_vbad = (i_rx_byte != s5c_pkg::SOCKS_VER);
                    end else if (r_idx == s5c_pkg::POS_REP) begin
                        if (r_vbad) begin
                            w_act.act    = s5c_pkg::ACT_REPORT;
                            w_act.status = s5c_pkg::ST_BAD_VER;
                        end else if (i_rx_byte >= s5c_pkg::REP_CODE_MIN &&
                                     i_rx_byte <= s5c_pkg::REP_CODE_MAX) begin
                            w_act.act    = s5c_pkg::ACT_REPORT;
                            w_act.status = s5c_pkg::ST_REPLY_BASE + i_rx_byte[3:0];
                        end else if (i_rx_byte != s5c_pkg::REP_SUCCESS) begin
                            w_act.act    = s5c_pkg::ACT_REPORT;
                            w_act.status = s5c_pkg::ST_UNKNOWN;
                        end
                    end else if (r_idx == s5c_pkg::POS_RSV) begin
                        if (i_rx_byte != s5c_pkg::RSV_BYTE) begin
                            w_act.act    = s5c_pkg::ACT_REPORT;
                            w_act.status = s5c_pkg::ST_RSV_NZ;
                        end
                    end else if (r_idx == s5c_pkg::POS_ATYP) begin
                        n_hacc = '0;
                        n_lacc = '0;
                        n_pacc = '0;
                        if (i_rx_byte == s5c_pkg::ATYP_V4) begin
                            n_v6 = 1'b0;
                        end else if (i_rx_byte == s5c_pkg::ATYP_V6) begin
                            n_v6 = 1'b1;
                        end else if (i_rx_byte == s5c_pkg::ATYP_DOMAIN) begin
                            w_act.act    = s5c_pkg::ACT_REPORT;
                            w_act.status = s5c_pkg::ST_DOMAIN;
                        end else begin
                            w_act.act    = s5c_pkg::ACT_REPORT;
                            w_act.status = s5c_pkg::ST_BAD_ATYP;
                        end
                    end else if (r_idx < w_addr_end) begin
                        // shift address bytes in, network order
                        if (r_v6 && r_idx < s5c_pkg::POS_V6_HI_END) begin
                            n_hacc = {r_hacc[55:0], i_rx_byte};
                        end else begin
                            n_lacc = {r_lacc[55:0], i_rx_byte};
                        end
                    end else begin
                        n_pacc = {r_pacc[7:0], i_rx_byte};
                        if (r_idx == w_addr_end + s5c_pkg::IDX_ONE) begin
                            w_act.act        = s5c_pkg::ACT_REPORT;
                            w_act.status     = s5c_pkg::ST_OK;
                            w_act.bound_v6   = r_v6;
                            w_act.bound_hi   = r_hacc;
                            w_act.bound_lo   = r_lacc;
                            w_act.bound_port = n_pacc;
                        end
                    end
                    // any report ends the handshake
                    if (w_act.act == s5c_pkg::ACT_REPORT) begin
                        n_phase = s5c_pkg::PH_DONE;
                        n_idx   = r_idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_action = w_act;

    // Advance parser state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s5c_pkg::PH_IDLE;
            r_idx   <= '0;
            r_vbad  <= 1'b0;
            r_v6    <= 1'b0;
            r_hacc  <= '0;
            r_lacc  <= '0;
            r_pacc  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_vbad  <= n_vbad;
            r_v6    <= n_v6;
            r_hacc  <= n_hacc;
            r_lacc  <= n_lacc;
            r_pacc  <= n_pacc;
        end
    end

    a_report_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_act.act == s5c_pkg::ACT_REPORT |=> r_phase == s5c_pkg::PH_DONE)
        else $error("report did not end the handshake");

    a_reply_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == s5c_pkg::PH_REPLY |-> r_idx <= s5c_pkg::LAST_V6)
        else $error("reply byte index out of range");

    a_connect_from_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_act.act == s5c_pkg::ACT_CONNECT |-> r_phase == s5c_pkg::PH_METHOD)
        else $error("connect request outside method phase");

endmodule

// ----- rtl/socks5_connect_handshake_client.sv -----
// Top level of the SOCKS5 no-auth CONNECT client: input stage, request emitter, result register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, i_command, i_rx_byte | to block
//  out     | o_out_valid/i_out_ready, o_kind .. o_bound_port | from block
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data            | to block
//
// One transaction is taken per cycle unless stalled. A start or a good method reply gives
// a 3-byte or a 10/22-byte request; the emitter sends one byte per cycle unless stalled;
// the input stage holds the next transaction until the last is sent. Reset (synchronous,
// active low) returns to idle with cleared target registers. A stalled output holds its
// result; one further transaction waits in the input register.
module socks5_connect_handshake_client (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_kind,
    output logic [7:0]                        o_tx_byte,
    output logic                              o_tx_last,
    output logic [3:0]                        o_status,
    output logic                              o_bound_is_v6,
    output logic [63:0]                       o_bound_addr_hi,
    output logic [63:0]                       o_bound_addr_lo,
    output logic [15:0]                       o_bound_port,
    input  logic                              i_cfg_we,
    input  logic [s5c_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                       i_cfg_data
);

    // Configuration
    logic        r_target_v6;
    logic [63:0] r_target_hi;
    logic [63:0] r_target_lo;
    logic [15:0] r_target_port;

    // Input stage
    logic        r_in_valid;
    logic        r_cmd;
    logic [7:0]  r_byte;

    // Emitter
    logic                      r_busy, n_busy;
    s5c_pkg::t_msg             r_msg, n_msg;
    logic [s5c_pkg::IDX_W-1:0] r_idx, n_idx;

    // Result register
    logic        r_o_valid, n_o_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic        r_tx_last, n_tx_last;
    logic [3:0]  r_status, n_status;
    logic        r_bv6, n_bv6;
    logic [63:0] r_bhi, n_bhi;
    logic [63:0] r_blo, n_blo;
    logic [15:0] r_bport, n_bport;

    logic                      w_out_free;
    logic                      w_step;
    logic                      w_in_take;
    s5c_pkg::t_action          w_action;
    logic [s5c_pkg::IDX_W-1:0] w_last;

    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_step     = r_in_valid && !r_busy && w_out_free;
    assign o_in_ready = !r_in_valid || w_step;
    assign w_in_take  = i_in_valid && o_in_ready;
    assign w_last     = s5c_pkg::msg_last_idx(r_msg, r_target_v6);

    s5c_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_command (r_cmd),
        .i_rx_byte (r_byte),
        .o_action  (w_action)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_v6   <= 1'b0;
            r_target_hi   <= '0;
            r_target_lo   <= '0;
            r_target_port <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                s5c_pkg::CFG_TARGET_IS_V6: r_target_v6   <= i_cfg_data[0];
                s5c_pkg::CFG_TARGET_HI:    r_target_hi   <= i_cfg_data;
                s5c_pkg::CFG_TARGET_LO:    r_target_lo   <= i_cfg_data;
                s5c_pkg::CFG_TARGET_PORT:  r_target_port <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the next transaction in the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd  <= i_command;
            r_byte <= i_rx_byte;
        end
    end

    // Emit request bytes or a report into the result register
    always_comb begin
        n_busy    = r_busy;
        n_msg     = r_msg;
        n_idx     = r_idx;
        n_o_valid = r_o_valid && !i_out_ready;
        n_kind    = r_kind;
        n_tx_byte = r_tx_byte;
        n_tx_last = r_tx_last;
        n_status  = r_status;
        n_bv6     = r_bv6;
        n_bhi     = r_bhi;
        n_blo     = r_blo;
        n_bport   = r_bport;
        if (r_busy && w_out_free) begin
            n_o_valid = 1'b1;
            n_kind    = s5c_pkg::KIND_TX;
            n_tx_byte = s5c_pkg::msg_byte(r_msg, r_idx, r_target_v6, r_target_hi,
                                          r_target_lo, r_target_port);
            n_tx_last = (r_idx == w_last);
            n_idx     = r_idx + s5c_pkg::IDX_ONE;
            n_busy    = (r_idx != w_last);
        end else if (w_step) begin
            case (w_action.act)
                s5c_pkg::ACT_HELLO, s5c_pkg::ACT_CONNECT: begin
                    n_msg     = (w_action.act == s5c_pkg::ACT_HELLO) ?
                                s5c_pkg::MSG_HELLO : s5c_pkg::MSG_CONNECT;
                    n_o_valid = 1'b1;
                    n_kind    = s5c_pkg::KIND_TX;
                    n_tx_byte = s5c_pkg::SOCKS_VER;
                    n_tx_last = 1'b0;
                    n_status  = s5c_pkg::ST_OK;
                    n_bv6     = 1'b0;
                    n_bhi     = '0;
                    n_blo     = '0;
                    n_bport   = '0;
                    n_idx     = s5c_pkg::IDX_ONE;
                    n_busy    = 1'b1;
                end
                s5c_pkg::ACT_REPORT: begin
                    n_o_valid = 1'b1;
                    n_kind    = s5c_pkg::KIND_REPORT;
                    n_tx_byte = 8'h00;
                    n_tx_last = 1'b0;
                    n_status  = w_action.status;
                    n_bv6     = w_action.bound_v6;
                    n_bhi     = w_action.bound_hi;
                    n_blo     = w_action.bound_lo;
                    n_bport   = w_action.bound_port;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
            r_msg     <= s5c_pkg::MSG_HELLO;
        end else begin
            r_busy    <= n_busy;
            r_o_valid <= n_o_valid;
            r_idx     <= n_idx;
            r_msg     <= n_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_tx_byte <= n_tx_byte;
        r_tx_last <= n_tx_last;
        r_status  <= n_status;
        r_bv6     <= n_bv6;
        r_bhi     <= n_bhi;
        r_blo     <= n_blo;
        r_bport   <= n_bport;
    end

    assign o_out_valid     = r_o_valid;
    assign o_kind          = r_kind;
    assign o_tx_byte       = r_tx_byte;
    assign o_tx_last       = r_tx_last;
    assign o_status        = r_status;
    assign o_bound_is_v6   = r_bv6;
    assign o_bound_addr_hi = r_bhi;
    assign o_bound_addr_lo = r_blo;
    assign o_bound_port    = r_bport;

    a_busy_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_o_valid)
        else $error("emitter busy without a pending result");

    a_busy_refills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_out_ready |=> r_o_valid && r_kind == s5c_pkg::KIND_TX)
        else $error("request byte not refilled after transfer");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_kind == s5c_pkg::KIND_REPORT |-> !r_tx_last && r_tx_byte == 8'h00)
        else $error("report carries transmit fields");

    a_no_step_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(r_busy) |-> $past(w_step))
        else $error("emitter started without a processed transaction");

endmodule
